### rtl/core/ctd_pkg.sv
// Shared types, constants and the compact-word decoder for the target difficulty unit.
// Used by ctd_div_stage and compact_target_difficulty_top; depends on nothing else.
package ctd_pkg;

    localparam int TGT_W           = 256;
    localparam int WORD_W          = 32;
    localparam int EXP_W           = 8;
    localparam int MANT_W          = 23;
    localparam int Q_W             = 64;
    localparam int MAX_SHIFT_BYTES = TGT_W / 8 - 1;
    localparam int SHIFT_BYTES_W   = $clog2(MAX_SHIFT_BYTES + 1);
    localparam int SEL_W           = $clog2(MANT_W);

    // Dividend bit positions run from the top of the widest shifted mantissa down to zero.
    localparam int STAGE_BITS = 4;
    localparam int NUM_POS    = ((8 * MAX_SHIFT_BYTES + MANT_W + STAGE_BITS - 1) / STAGE_BITS)
                                * STAGE_BITS;
    localparam int NUM_STAGES = NUM_POS / STAGE_BITS;
    localparam int TOP_POS    = NUM_POS - 1;
    localparam int IDX_W      = $clog2(TOP_POS + 8 * MAX_SHIFT_BYTES + 1) + 1;

    localparam logic [WORD_W-1:0] GENESIS_RESET = 32'h1D00FFFF;

    typedef struct packed {
        logic [MANT_W-1:0]        mant;
        logic [SHIFT_BYTES_W-1:0] shift_bytes;
    } ctd_decoded_t;

    // One item in flight through the divider chain.
    typedef struct packed {
        logic                     zero;
        logic [MANT_W-1:0]        divisor;
        logic [MANT_W-1:0]        dividend;
        logic signed [IDX_W-1:0]  idx;
        logic [MANT_W-1:0]        rem;
        logic [Q_W-1:0]           quot;
    } ctd_stage_t;

    // A decoded target equals mant * 2^(8 * shift_bytes); mant is zero exactly when the
    // target is zero. Bits pushed past the top of the target are masked off here.
    function automatic ctd_decoded_t decode(input logic [WORD_W-1:0] word);
        logic [EXP_W-1:0]  n;
        logic [MANT_W-1:0] m;
        ctd_decoded_t      d;
        int                kept;
        n              = word[WORD_W-1 -: EXP_W];
        m              = word[MANT_W-1:0];
        d.mant         = '0;
        d.shift_bytes  = '0;
        kept           = 0;
        if (n <= EXP_W'(3))
        begin
            d.mant = m >> {(2'd3 - n[1:0]), 3'b000};
        end
        else if (n <= EXP_W'(MAX_SHIFT_BYTES + 3))
        begin
            d.shift_bytes = SHIFT_BYTES_W'(n - EXP_W'(3));
            kept          = TGT_W - 8 * int'(d.shift_bytes);
            for (int i = 0; i < MANT_W; i++)
            begin
                d.mant[i] = m[i] && (i < kept);
            end
        end
        return d;
    endfunction

endpackage

### rtl/core/ctd_div_stage.sv
// One register stage of the restoring divider: STAGE_BITS dividend bits per stage.
// Depends on ctd_pkg for the stage record and sizes.
module ctd_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ctd_pkg::ctd_stage_t in_data,
    output logic                out_valid,
    output ctd_pkg::ctd_stage_t out_data
);

    logic                valid_reg;
    ctd_pkg::ctd_stage_t data_reg;
    ctd_pkg::ctd_stage_t data_next;

    always_comb
    begin
        logic signed [ctd_pkg::IDX_W-1:0] pos;
        logic                             in_bit;
        logic [ctd_pkg::MANT_W:0]         trial;
        logic [ctd_pkg::MANT_W-1:0]       rem_w;
        logic [ctd_pkg::Q_W-1:0]          quot_w;
        logic                             q_bit;
        rem_w  = in_data.rem;
        quot_w = in_data.quot;
        for (int j = 0; j < ctd_pkg::STAGE_BITS; j++)
        begin
            // The dividend is the genesis mantissa placed at idx; positions outside it are zero.
            pos    = in_data.idx - ctd_pkg::IDX_W'(j);
            in_bit = (pos >= 0 && pos < ctd_pkg::MANT_W) ?
                     in_data.dividend[pos[ctd_pkg::SEL_W-1:0]] : 1'b0;
            trial  = {rem_w, in_bit};
            q_bit  = (trial >= {1'b0, in_data.divisor});
            if (q_bit)
            begin
                trial = trial - {1'b0, in_data.divisor};
            end
            rem_w  = trial[ctd_pkg::MANT_W-1:0];
            quot_w = {quot_w[ctd_pkg::Q_W-2:0], q_bit};
        end
        data_next      = in_data;
        data_next.idx  = in_data.idx - ctd_pkg::IDX_W'(ctd_pkg::STAGE_BITS);
        data_next.rem  = rem_w;
        data_next.quot = quot_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/compact_target_difficulty_top.sv
// Compact target difficulty unit: low 64 bits of genesis target / item target.
// Pipeline: one decode stage, 68 divider stages of 4 bits, one output register.
// Throughput is one transfer per cycle; the whole pipeline holds while a result is not taken.
// Reset (rst_n, asynchronous) empties the pipeline and loads the genesis word 0x1D00FFFF.
// Depends on ctd_pkg and ctd_div_stage.
module compact_target_difficulty_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         genesis_we,
    input  logic [ctd_pkg::WORD_W-1:0]   genesis_compact,
    input  logic                         target_valid,
    output logic                         target_ready,
    input  logic [ctd_pkg::WORD_W-1:0]   compact_target,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [ctd_pkg::Q_W-1:0]      difficulty,
    output logic                         zero_target
);

    logic [ctd_pkg::WORD_W-1:0] genesis_reg;
    logic                       en;
    ctd_pkg::ctd_decoded_t      tgt_dec;
    ctd_pkg::ctd_decoded_t      gen_dec;
    ctd_pkg::ctd_stage_t        entry_next;
    ctd_pkg::ctd_stage_t        entry_reg;
    logic                       entry_valid_reg;
    ctd_pkg::ctd_stage_t        stage_data [ctd_pkg::NUM_STAGES+1];
    logic                       stage_valid [ctd_pkg::NUM_STAGES+1];
    logic                       result_valid_reg;
    logic [ctd_pkg::Q_W-1:0]    difficulty_reg;
    logic                       zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            genesis_reg <= ctd_pkg::GENESIS_RESET;
        end
        else if (genesis_we)
        begin
            genesis_reg <= genesis_compact;
        end
    end

    assign en           = !result_valid_reg || result_ready;
    assign target_ready = en;

    // Common powers of two cancel, so the divider sees the genesis mantissa placed at bit
    // 8 * (genesis shift - target shift) and divides by the bare target mantissa.
    always_comb
    begin
        tgt_dec             = ctd_pkg::decode(compact_target);
        gen_dec             = ctd_pkg::decode(genesis_reg);
        entry_next.zero     = (tgt_dec.mant == '0) || (gen_dec.mant == '0);
        entry_next.divisor  = tgt_dec.mant;
        entry_next.dividend = gen_dec.mant;
        entry_next.idx      = ctd_pkg::IDX_W'(ctd_pkg::TOP_POS)
                              - ctd_pkg::IDX_W'({gen_dec.shift_bytes, 3'b000})
                              + ctd_pkg::IDX_W'({tgt_dec.shift_bytes, 3'b000});
        entry_next.rem      = '0;
        entry_next.quot     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= target_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign stage_data[0]  = entry_reg;
    assign stage_valid[0] = entry_valid_reg;

    for (genvar g = 0; g < ctd_pkg::NUM_STAGES; g++)
    begin : g_div
        ctd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= stage_valid[ctd_pkg::NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg       <= stage_data[ctd_pkg::NUM_STAGES].zero;
            difficulty_reg <= stage_data[ctd_pkg::NUM_STAGES].zero ?
                              '0 : stage_data[ctd_pkg::NUM_STAGES].quot;
        end
    end

    assign result_valid = result_valid_reg;
    assign difficulty   = difficulty_reg;
    assign zero_target  = zero_reg;

`ifndef SYNTHESIS
    // A zero target must never report a nonzero difficulty.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_target |-> difficulty == '0)
        else $error("zero target with nonzero difficulty");

    // The remainder leaving the last divider stage is below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[ctd_pkg::NUM_STAGES] && !stage_data[ctd_pkg::NUM_STAGES].zero
        |-> stage_data[ctd_pkg::NUM_STAGES].rem < stage_data[ctd_pkg::NUM_STAGES].divisor)
        else $error("divider remainder out of range");

    // An item leaving the last divider stage reaches the output register.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && stage_valid[ctd_pkg::NUM_STAGES] |=> result_valid)
        else $error("result lost at output register");
`endif

endmodule

### sim/compact_target_difficulty_top_tb.sv
// Self-checking testbench for compact_target_difficulty_top: a directed table, then random
// compact targets under a range of genesis words. Depends on ctd_pkg and the unit's RTL.
module compact_target_difficulty_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_DIRECTED   = 21;
    localparam int  N_PHASES     = 9;
    localparam int  PHASE_ITEMS  = 50;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  TAIL_CYCLES  = 80;
    localparam int  EXPECT_DEPTH = 256;
    localparam bit  TYPED        = 1'b1;
    localparam bit  PRED         = 1'b0;

    typedef struct packed {
        logic [ctd_pkg::Q_W-1:0] difficulty;
        logic                    zero;
    } difficulty_t;

    typedef struct packed {
        logic [ctd_pkg::WORD_W-1:0] word;
        logic                       typed;
        logic [ctd_pkg::Q_W-1:0]    difficulty;
        logic                       zero;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       genesis_we = 1'b0;
    logic [ctd_pkg::WORD_W-1:0] genesis_compact = '0;
    logic                       target_valid = 1'b0;
    logic                       target_ready;
    logic [ctd_pkg::WORD_W-1:0] compact_target = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [ctd_pkg::Q_W-1:0]    difficulty;
    logic                       zero_target;

    logic [ctd_pkg::WORD_W-1:0] genesis_model = ctd_pkg::GENESIS_RESET;
    // Expected results in transfer order; the write and read counts only ever grow.
    difficulty_t                expect_mem [EXPECT_DEPTH];
    int                         expect_wr = 0;
    int                         expect_rd = 0;
    bit                         gaps_on = 1'b1;
    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         targets_sent = 0;
    int                         results_seen = 0;
    int                         zero_results = 0;

    // Directed rows run under the reset genesis word 0x1D00FFFF.
    stim_row_t directed_rows [N_DIRECTED] = '{
        {32'h1D00FFFF, TYPED, 64'd1, 1'b0},   // target equal to genesis
        {32'h1D80FFFF, TYPED, 64'd1, 1'b0},   // sign bit has no effect
        {32'h00000000, TYPED, 64'd0, 1'b1},
        {32'h1D000000, TYPED, 64'd0, 1'b1},   // zero mantissa, large exponent
        {32'h00FFFFFF, TYPED, 64'd0, 1'b1},   // mantissa shifted out to the right
        {32'h00800000, TYPED, 64'd0, 1'b1},
        {32'h01FFFFFF, PRED,  64'd0, 1'b0},
        {32'h02FFFFFF, PRED,  64'd0, 1'b0},
        {32'h03FFFFFF, PRED,  64'd0, 1'b0},
        {32'h03000001, TYPED, 64'd0, 1'b0},   // quotient wider than 64 bits
        {32'h23000001, TYPED, 64'd0, 1'b1},   // shift past the top of the target
        {32'hFF7FFFFF, TYPED, 64'd0, 1'b1},
        {32'h207FFFFF, TYPED, 64'd0, 1'b0},   // target above genesis
        {32'h227FFFFF, TYPED, 64'd0, 1'b0},   // mantissa partly truncated
        {32'h22000100, TYPED, 64'd0, 1'b1},   // mantissa truncated to nothing
        {32'h1C00FFFF, TYPED, 64'd256, 1'b0},
        {32'h1D008000, TYPED, 64'd1, 1'b0},
        {32'h1A7FFFFF, PRED,  64'd0, 1'b0},
        {32'h0F123456, PRED,  64'd0, 1'b0},
        {32'h16000001, PRED,  64'd0, 1'b0},
        {32'h17000001, PRED,  64'd0, 1'b0}
    };

    compact_target_difficulty_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .genesis_we      (genesis_we),
        .genesis_compact (genesis_compact),
        .target_valid    (target_valid),
        .target_ready    (target_ready),
        .compact_target  (compact_target),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .difficulty      (difficulty),
        .zero_target     (zero_target)
    );

    always #10 clk = ~clk;

    function automatic logic [ctd_pkg::TGT_W-1:0] expand_compact(
        input logic [ctd_pkg::WORD_W-1:0] w);
        int                         n;
        logic [ctd_pkg::TGT_W-1:0]  t;
        n = int'(w[31:24]);
        t = {{(ctd_pkg::TGT_W-ctd_pkg::MANT_W){1'b0}}, w[ctd_pkg::MANT_W-1:0]};
        if (n <= 3)
            t = t >> (8 * (3 - n));
        else if (n - 3 < ctd_pkg::TGT_W / 8)
            t = t << (8 * (n - 3));
        else
            t = '0;
        return t;
    endfunction

    function automatic difficulty_t predict_difficulty(
        input logic [ctd_pkg::WORD_W-1:0] target_word,
        input logic [ctd_pkg::WORD_W-1:0] genesis_word);
        logic [ctd_pkg::TGT_W-1:0] num;
        logic [ctd_pkg::TGT_W-1:0] den;
        logic [ctd_pkg::TGT_W-1:0] quot;
        difficulty_t               r;
        num = expand_compact(genesis_word);
        den = expand_compact(target_word);
        if (num == '0 || den == '0)
        begin
            r.difficulty = '0;
            r.zero       = 1'b1;
        end
        else
        begin
            quot         = num / den;
            r.difficulty = quot[ctd_pkg::Q_W-1:0];
            r.zero       = 1'b0;
        end
        return r;
    endfunction

    // Nearly half of the targets land near the genesis exponent so that quotients stay interesting.
    function automatic logic [ctd_pkg::WORD_W-1:0] random_target(
        input logic [ctd_pkg::WORD_W-1:0] genesis_word);
        int          pick;
        int          n;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        if (pick < 45)
            n = int'(genesis_word[31:24]) + $urandom_range(0, 10) - 8;
        else if (pick < 65)
            n = $urandom_range(0, 3);
        else if (pick < 80)
            n = $urandom_range(0, 36);
        else
            return $urandom;
        if (n < 0)
            n = 0;
        if (n > 255)
            n = 255;
        return {n[7:0], r[23:0]};
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_target(input logic [ctd_pkg::WORD_W-1:0] w, input logic typed,
                               input difficulty_t typed_result);
        if (gaps_on && $urandom_range(0, 99) < 16)
        begin
            target_valid = 1'b0;
            @(negedge clk);
        end
        target_valid   = 1'b1;
        compact_target = w;
        @(posedge clk);
        while (!target_ready)
            @(posedge clk);
        expect_mem[expect_wr % EXPECT_DEPTH] = typed ? typed_result
                                                     : predict_difficulty(w, genesis_model);
        expect_wr++;
        targets_sent++;
        @(negedge clk);
    endtask

    // Only written with nothing in flight, since every target yields one result.
    task automatic write_genesis(input logic [ctd_pkg::WORD_W-1:0] value);
        target_valid = 1'b0;
        while (expect_wr != expect_rd)
            @(negedge clk);
        genesis_we      = 1'b1;
        genesis_compact = value;
        @(negedge clk);
        genesis_we      = 1'b0;
        genesis_model   = value;
    endtask

    always @(negedge clk)
        result_ready = gaps_on ? ($urandom_range(0, 99) >= 14) : 1'b1;

    always @(posedge clk)
    begin
        difficulty_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("compact_target_difficulty_top_tb: errors");
            $finish;
        end
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expect_wr == expect_rd)
            begin
                error_count++;
                $display("%0t: result with nothing expected: difficulty %h zero %b",
                         $time, difficulty, zero_target);
            end
            else
            begin
                want = expect_mem[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                if (want.zero)
                    zero_results++;
                if (difficulty !== want.difficulty)
                begin
                    error_count++;
                    $display("%0t: difficulty expected %h actual %h",
                             $time, want.difficulty, difficulty);
                end
                if (zero_target !== want.zero)
                begin
                    error_count++;
                    $display("%0t: zero_target expected %b actual %b",
                             $time, want.zero, zero_target);
                end
            end
        end
    end

    initial
    begin
        logic [ctd_pkg::WORD_W-1:0] genesis_list [N_PHASES];
        logic [31:0]                r;
        r = $urandom;
        genesis_list[0] = 32'h1D00FFFF;
        genesis_list[1] = 32'h00000000;
        genesis_list[2] = 32'h207FFFFF;
        genesis_list[3] = 32'hFFFFFFFF;
        genesis_list[4] = 32'h03000001;
        genesis_list[5] = 32'h227FFFFF;
        genesis_list[6] = 32'h1B0404CB;
        genesis_list[7] = {8'($urandom_range(4, 34)), r[23:0]};
        genesis_list[8] = $urandom;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            push_target(directed_rows[i].word, directed_rows[i].typed,
                        {directed_rows[i].difficulty, directed_rows[i].zero});
        target_valid = 1'b0;

        for (int p = 0; p < N_PHASES; p++)
        begin
            // One phase runs with both sides at full rate.
            gaps_on = (p != 2);
            write_genesis(genesis_list[p]);
            repeat (PHASE_ITEMS)
                push_target(random_target(genesis_model), PRED, '0);
            target_valid = 1'b0;
        end

        gaps_on = 1'b1;
        while (expect_wr != expect_rd)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d compact targets under %0d genesis words; %0d results checked.",
                 targets_sent, N_PHASES, results_seen);
        $display("%0d results had a zero target; %0d mismatches.", zero_results, error_count);
        if (error_count == 0)
            $display("compact_target_difficulty_top_tb: clean");
        else
            $display("compact_target_difficulty_top_tb: errors");
        $finish;
    end

endmodule

### files.f
rtl/core/ctd_pkg.sv
rtl/core/ctd_div_stage.sv
rtl/core/compact_target_difficulty_top.sv
sim/compact_target_difficulty_top_tb.sv
